FILE: src/bilinear_upscale_2x_core_defines.svh
// Assertion macros used by the checker file of the 2x upscaler.
`ifndef BILINEAR_UPSCALE_2X_CORE_DEFINES_SVH
`define BILINEAR_UPSCALE_2X_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BU2X_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BU2X_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bu2x_pkg.sv
// Package: widths, register indexes and result kinds of the 2x upscaler.
package bu2x_pkg;

  localparam int PIX_IN_W  = 8;
  localparam int COORD_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 10;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;
  localparam int HEIGHT_LIMIT   = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } cfg_reg_t;

  // Order in which the words of one source pixel leave the block.
  typedef enum logic [1:0] {
    KIND_SELF = 2'd0,
    KIND_LEFT = 2'd1,
    KIND_UP   = 2'd2,
    KIND_QUAD = 2'd3
  } kind_t;

endpackage

FILE: src/bu2x_ifs.sv
// Channel interfaces: source pixels, result words, register writes.
interface bu2x_src_if;
  import bu2x_pkg::*;
  logic                valid;
  logic                ready;
  logic [PIX_IN_W-1:0] src_pixel;
  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

interface bu2x_res_if;
  import bu2x_pkg::*;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  out_row;
  logic [COORD_W-1:0]  out_col;
  logic [PIX_IN_W-1:0] out_value;
  logic                last_of_run;
  logic                frame_done;
  modport source (output valid, output out_row, output out_col, output out_value,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input last_of_run, input frame_done, output ready);
endinterface

interface bu2x_cfg_if;
  import bu2x_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/bilinear_upscale_2x_core.sv
// Top level: streaming 2x bilinear upscaler with line buffer and word sequencer.
//
//  channel | dir | words                          | handshake
//  src     | in  | one source pixel, row-major    | valid/ready
//  res     | out | row, col, value, run/frame end | valid/ready
//  cfg     | in  | register index + data          | valid/ready, ready always 1
//
// One source pixel gives 1 to 4 result words; the single output register sends
// one word per cycle while res is ready; a pixel holds the sequencer until its last word.
// A pixel moves through the input register and the sequencer to the output register.
// An input register and the output register let the next pixel come in while
// words still wait on res. rst is synchronous; the line buffer is not cleared.
module bilinear_upscale_2x_core #(
  parameter int MAX_WIDTH  = bu2x_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bu2x_pkg::DEF_PIXEL_BITS
) (
  input logic        clk,
  input logic        rst,
  bu2x_src_if.sink   src,
  bu2x_res_if.source res,
  bu2x_cfg_if.sink   cfg
);
  import bu2x_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int PB = PIXEL_BITS;

  // configuration
  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;

  // position and neighbor registers
  logic [ROW_W-1:0] row_pos;
  logic [CW-1:0]    col_pos;
  logic [PB-1:0]    left_pixel;

  // line buffer
  logic [PB-1:0] line_mem [MAX_WIDTH];
  logic [PB-1:0] rd_data;

  // input stage
  logic             a_valid;
  logic [PB-1:0]    a_p;
  logic [PB-1:0]    a_left;
  logic [PB-1:0]    a_upleft;
  logic [ROW_W-1:0] a_r;
  logic [CW-1:0]    a_c;
  logic             a_last;

  // sequencer stage
  logic             b_valid;
  logic [PB-1:0]    b_p;
  logic [PB-1:0]    b_up;
  logic [PB-1:0]    b_left;
  logic [PB-1:0]    b_upleft;
  logic [ROW_W-1:0] b_r;
  logic [CW-1:0]    b_c;
  logic             b_last;
  kind_t            b_kind;

  // output register
  logic                o_valid;
  logic [COORD_W-1:0]  o_row;
  logic [COORD_W-1:0]  o_col;
  logic [PIX_IN_W-1:0] o_value;
  logic                o_lor;
  logic                o_fd;

  // combinational
  logic [WW-1:0]          w;
  logic [CFG_W-1:0]       h;
  logic                   col_wrap;
  logic [CFG_W-1:0]       row_try;
  logic [ROW_W-1:0]       cur_r;
  logic [CW-1:0]          cur_c;
  logic [WW-1:0]          col_inc;
  logic [CFG_W-1:0]       row_inc;
  logic [ROW_W-1:0]       row_next;
  logic [CW-1:0]          col_next;
  logic                   cur_last;
  logic [PB+PIX_IN_W-1:0] pin_wide;
  logic [PB-1:0]          p;

  logic  accept;
  logic  out_load;
  logic  b_fire;
  logic  b_done;
  logic  a_move;
  logic  has_left;
  logic  has_up;
  logic  b_more;
  kind_t kind_next;

  logic [PB:0]                sum_left;
  logic [PB:0]                sum_up;
  logic [PB+1:0]              sum_quad;
  logic [PB-1:0]              val_sel;
  logic [PB+PIX_IN_W-1:0]     val_wide;
  logic [COORD_W-1:0]         r2;
  logic [COORD_W-1:0]         row_sel;
  logic [CW:0]                c2;
  logic [CW:0]                col_sel;
  logic [CW+COORD_W:0]        col_wide;

  // ---------------- configuration ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= WIDTH_RESET;
      src_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SRC_WIDTH:  src_width  <= cfg.data;
        REG_SRC_HEIGHT: src_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // zero counts as 1, oversize saturates
  always_comb begin
    if (src_width == '0) begin
      w = WW'(1);
    end else if (WW'(src_width) > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(src_width);
    end
    if (src_height == '0) begin
      h = CFG_W'(1);
    end else if (src_height > CFG_W'(HEIGHT_LIMIT)) begin
      h = CFG_W'(HEIGHT_LIMIT);
    end else begin
      h = src_height;
    end
  end

  // ---------------- position ----------------
  // counters may sit beyond a size that shrank in mid-frame: wrap first
  always_comb begin
    col_wrap = WW'(col_pos) >= w;
    row_try  = col_wrap ? CFG_W'(row_pos) + 1'b1 : CFG_W'(row_pos);
    cur_r    = (row_try >= h) ? '0 : row_try[ROW_W-1:0];
    cur_c    = col_wrap ? '0 : col_pos;
    cur_last = (CFG_W'(cur_r) == h - 1'b1) && (WW'(cur_c) == w - 1'b1);
    col_inc  = WW'(cur_c) + 1'b1;
    row_inc  = CFG_W'(cur_r) + 1'b1;
    if (col_inc >= w) begin
      col_next = '0;
      row_next = (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = cur_r;
    end
  end

  assign pin_wide = (PB + PIX_IN_W)'(src.src_pixel);
  assign p        = pin_wide[PB-1:0];

  // ---------------- handshakes ----------------
  assign out_load  = !o_valid || res.ready;
  assign b_fire    = b_valid && out_load;
  assign b_done    = b_fire && !b_more;
  assign a_move    = a_valid && (!b_valid || b_done);
  assign src.ready = !a_valid || a_move;
  assign accept    = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos    <= '0;
      col_pos    <= '0;
      left_pixel <= '0;
    end else if (accept) begin
      row_pos    <= row_next;
      col_pos    <= col_next;
      left_pixel <= p;
    end
  end

  // ---------------- line buffer ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[cur_c] <= p;
    end
  end

  // read-before-write: the old entry is the pixel above
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[cur_c];
    end
  end

  // ---------------- input stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  // rd_data still holds the previous pixel's up value, which is this one's upleft
  always_ff @(posedge clk) begin
    if (accept) begin
      a_p      <= p;
      a_left   <= left_pixel;
      a_upleft <= rd_data;
      a_r      <= cur_r;
      a_c      <= cur_c;
      a_last   <= cur_last;
    end
  end

  // ---------------- sequencer ----------------
  assign has_left = b_c != '0;
  assign has_up   = b_r != '0;

  always_comb begin
    case (b_kind)
      KIND_SELF: begin
        kind_next = has_left ? KIND_LEFT : KIND_UP;
        b_more    = has_left || has_up;
      end
      KIND_LEFT: begin
        kind_next = KIND_UP;
        b_more    = has_up;
      end
      KIND_UP: begin
        kind_next = KIND_QUAD;
        b_more    = has_left;
      end
      default: begin
        kind_next = KIND_QUAD;
        b_more    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_kind  <= KIND_SELF;
    end else if (a_move) begin
      b_valid <= 1'b1;
      b_kind  <= KIND_SELF;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end else if (b_fire) begin
      b_kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_p      <= a_p;
      b_up     <= rd_data;
      b_left   <= a_left;
      b_upleft <= a_upleft;
      b_r      <= a_r;
      b_c      <= a_c;
      b_last   <= a_last;
    end
  end

  // averages, rounded half up
  always_comb begin
    sum_left = (PB + 1)'(b_left) + (PB + 1)'(b_p) + 1'b1;
    sum_up   = (PB + 1)'(b_up) + (PB + 1)'(b_p) + 1'b1;
    sum_quad = (PB + 2)'(b_upleft) + (PB + 2)'(b_up) + (PB + 2)'(b_left)
             + (PB + 2)'(b_p) + 2'd2;
    r2       = COORD_W'({b_r, 1'b0});
    c2       = {b_c, 1'b0};
    case (b_kind)
      KIND_SELF: begin
        val_sel = b_p;
        row_sel = r2;
        col_sel = c2;
      end
      KIND_LEFT: begin
        val_sel = sum_left[PB:1];
        row_sel = r2;
        col_sel = c2 - 1'b1;
      end
      KIND_UP: begin
        val_sel = sum_up[PB:1];
        row_sel = r2 - 1'b1;
        col_sel = c2;
      end
      default: begin
        val_sel = sum_quad[PB+1:2];
        row_sel = r2 - 1'b1;
        col_sel = c2 - 1'b1;
      end
    endcase
    val_wide = (PB + PIX_IN_W)'(val_sel);
    col_wide = (CW + COORD_W + 1)'(col_sel);
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      o_row   <= row_sel;
      o_col   <= col_wide[COORD_W-1:0];
      o_value <= val_wide[PIX_IN_W-1:0];
      o_lor   <= !b_more;
      o_fd    <= !b_more && b_last;
    end
  end

  assign res.valid       = o_valid;
  assign res.out_row     = o_row;
  assign res.out_col     = o_col;
  assign res.out_value   = o_value;
  assign res.last_of_run = o_lor;
  assign res.frame_done  = o_fd;

endmodule

FILE: src/bu2x_checker.sv
// Port-level checker for the 2x upscaler, bound to the top level.
`include "bilinear_upscale_2x_core_defines.svh"

module bu2x_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [bu2x_pkg::COORD_W-1:0]  out_row,
  input logic [bu2x_pkg::COORD_W-1:0]  out_col,
  input logic [bu2x_pkg::PIX_IN_W-1:0] out_value,
  input logic                          last_of_run,
  input logic                          frame_done
);
  import bu2x_pkg::*;

  logic res_acc;
  logic run_start;

  assign res_acc = res_valid && res_ready;

  // next word opens a run: the one after a run end, or the first after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      run_start <= 1'b1;
    end else if (res_acc) begin
      run_start <= last_of_run;
    end
  end

  `BU2X_ASSERT_IMPL(a_frame_ends_run, res_valid && frame_done, last_of_run,
    "frame_done on a word that does not end its run")

  `BU2X_ASSERT_IMPL(a_run_opens_even, res_acc && run_start,
    !out_row[0] && !out_col[0], "run does not open on the source pixel itself")

  `BU2X_ASSERT_IMPL(a_inner_word_odd, res_acc && !run_start,
    out_row[0] || out_col[0], "interpolated word on an even-even position")

  `BU2X_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(out_row) && $stable(out_col) && $stable(out_value)
    && $stable(last_of_run) && $stable(frame_done), "stalled result word changed")

endmodule

bind bilinear_upscale_2x_core bu2x_checker u_bu2x_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .out_row     (res.out_row),
  .out_col     (res.out_col),
  .out_value   (res.out_value),
  .last_of_run (res.last_of_run),
  .frame_done  (res.frame_done)
);

FILE: tb/bilinear_upscale_2x_core_tb.sv
// Testbench for the 2x bilinear upscaler: directed table, random frames, self-checking.
`timescale 1ns / 100ps

module bilinear_upscale_2x_core_tb;
  import bu2x_pkg::*;

  localparam int RANDOM_ITEMS = 256;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [PIX_IN_W-1:0] value;
    logic                run_end;
    logic                frame_end;
  } out_word_t;

  typedef enum logic {DO_PIX, DO_REG} step_act_t;

  // typed = 1: the pixel gives one word, written out here in full
  typedef struct packed {
    step_act_t           act;
    cfg_reg_t            sel;
    logic [CFG_W-1:0]    reg_val;
    logic [PIX_IN_W-1:0] pix;
    logic                typed;
    out_word_t           want;
  } step_t;

  localparam out_word_t NO_WORD = '0;

  localparam int NUM_STEPS = 29;
  step_t dir_steps [NUM_STEPS] = '{
    // reset size 640x480: first pixel lands at (0,0)
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h00, 1'b1, '{11'd0, 11'd0, 8'h00, 1'b1, 1'b0}},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    // zero sizes act as 1x1, mid-frame: every pixel is a whole frame
    '{DO_REG, REG_SRC_WIDTH,  11'd0,    8'h00, 1'b0, NO_WORD},
    '{DO_REG, REG_SRC_HEIGHT, 11'd0,    8'h00, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hA5, 1'b1, '{11'd0, 11'd0, 8'hA5, 1'b1, 1'b1}},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h5A, 1'b1, '{11'd0, 11'd0, 8'h5A, 1'b1, 1'b1}},
    // 2x2 frames: rounding at the extremes
    '{DO_REG, REG_SRC_WIDTH,  11'd2,    8'h00, 1'b0, NO_WORD},
    '{DO_REG, REG_SRC_HEIGHT, 11'd2,    8'h00, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h00, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h00, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    // oversize registers saturate
    '{DO_REG, REG_SRC_WIDTH,  11'd2047, 8'h00, 1'b0, NO_WORD},
    '{DO_REG, REG_SRC_HEIGHT, 11'd1024, 8'h00, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h01, 1'b1, '{11'd0, 11'd0, 8'h01, 1'b1, 1'b0}},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h02, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFE, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h80, 1'b0, NO_WORD},
    // shrink mid-row: column past the new width wraps to the next row
    '{DO_REG, REG_SRC_WIDTH,  11'd3,    8'h00, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h7F, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h80, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hFF, 1'b0, NO_WORD},
    // row beyond the new height wraps to 0
    '{DO_REG, REG_SRC_HEIGHT, 11'd2,    8'h00, 1'b0, NO_WORD},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'h3C, 1'b1, '{11'd0, 11'd0, 8'h3C, 1'b1, 1'b0}},
    '{DO_PIX, REG_SRC_WIDTH,  11'd0,    8'hC3, 1'b0, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  bu2x_src_if src_ch ();
  bu2x_res_if res_ch ();
  bu2x_cfg_if cfg_ch ();

  bilinear_upscale_2x_core u_dut (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scaler model state
  logic [CFG_W-1:0]    width_reg  = WIDTH_RESET;
  logic [CFG_W-1:0]    height_reg = HEIGHT_RESET;
  logic [PIX_IN_W-1:0] line_buf [DEF_MAX_WIDTH];
  bit                  col_written [DEF_MAX_WIDTH];
  logic [PIX_IN_W-1:0] left_pix   = '0;
  logic [PIX_IN_W-1:0] upleft_pix = '0;
  int                  row_at = 0;
  int                  col_at = 0;

  out_word_t expected_words [$];
  step_t     given_q [$];

  bit calm = 1'b0;
  int mismatches  = 0;
  int pixels_in   = 0;
  int words_out   = 0;
  int frames_done = 0;
  int reg_writes  = 0;

  initial begin
    foreach (line_buf[k]) line_buf[k] = '0;
  end

  function automatic int eff_size(logic [CFG_W-1:0] v, int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // pending position past the current size wraps before the pixel is placed
  function automatic void wrap_pos(input int w, input int h, inout int r, inout int c);
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
  endfunction

  function automatic out_word_t mk_word(int r, int c, int v);
    return '{COORD_W'(r), COORD_W'(c), PIX_IN_W'(v), 1'b0, 1'b0};
  endfunction

  task automatic scale_pixel(input logic [PIX_IN_W-1:0] p, output out_word_t words [4],
                             output int n);
    int w, h, r, c, up;
    w = eff_size(width_reg, DEF_MAX_WIDTH);
    h = eff_size(height_reg, HEIGHT_LIMIT);
    wrap_pos(w, h, row_at, col_at);
    r = row_at;
    c = col_at;
    up = int'(line_buf[c]);
    words[0] = mk_word(2 * r, 2 * c, int'(p));
    n = 1;
    if (c > 0) begin
      words[n] = mk_word(2 * r, 2 * c - 1, (int'(left_pix) + int'(p) + 1) >> 1);
      n++;
    end
    if (r > 0) begin
      words[n] = mk_word(2 * r - 1, 2 * c, (up + int'(p) + 1) >> 1);
      n++;
    end
    if (r > 0 && c > 0) begin
      words[n] = mk_word(2 * r - 1, 2 * c - 1,
                         (int'(upleft_pix) + up + int'(left_pix) + int'(p) + 2) >> 2);
      n++;
    end
    words[n-1].run_end = 1'b1;
    if (r == h - 1 && c == w - 1) words[n-1].frame_end = 1'b1;
    upleft_pix = PIX_IN_W'(up);
    left_pix = p;
    line_buf[c] = p;
    col_written[c] = 1'b1;
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) row_at = 0;
    end
  endtask

  // a row r > 0 must only read line buffer columns that were already written
  function automatic bit width_safe(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
    int w, h, r, c;
    w = eff_size(wv, DEF_MAX_WIDTH);
    h = eff_size(hv, HEIGHT_LIMIT);
    r = row_at;
    c = col_at;
    wrap_pos(w, h, r, c);
    if (r == 0) return 1'b1;
    for (int k = c; k < w; k++) if (!col_written[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [CFG_W-1:0] pick_size(int small_hi);
    case ($urandom_range(0, 23))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(1024);
      3:       return CFG_W'(1025);
      4:       return CFG_W'($urandom_range(0, 2047));
      default: return CFG_W'($urandom_range(1, small_hi));
    endcase
  endfunction

  function automatic logic [PIX_IN_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_IN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endtask

  // returns at the edge that takes the word
  task automatic push_pixel(input logic [PIX_IN_W-1:0] p);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 16) begin
      src_ch.valid <= 1'b0;
      @(negedge clk);
    end
    src_ch.valid <= 1'b1;
    src_ch.src_pixel <= p;
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // stop both senders and wait for every pending word
  task automatic settle();
    @(negedge clk);
    src_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) res_ch.ready <= calm || $urandom_range(0, 99) >= 16;

  always @(posedge clk) begin : track_blk
    out_word_t words [4];
    int n;
    step_t given;
    out_word_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_SRC_WIDTH) width_reg = cfg_ch.data;
        else height_reg = cfg_ch.data;
        reg_writes++;
      end
      if (src_ch.valid && src_ch.ready) begin
        scale_pixel(src_ch.src_pixel, words, n);
        given = '0;
        if (given_q.size() != 0) given = given_q.pop_front();
        if (given.typed) expected_words.push_back(given.want);
        else for (int k = 0; k < n; k++) expected_words.push_back(words[k]);
        pixels_in++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("word %0d not expected: row %0d col %0d value %0d",
                                  words_out, res_ch.out_row, res_ch.out_col,
                                  res_ch.out_value));
        end else begin
          want = expected_words.pop_front();
          if (res_ch.out_row !== want.row || res_ch.out_col !== want.col ||
              res_ch.out_value !== want.value || res_ch.last_of_run !== want.run_end ||
              res_ch.frame_done !== want.frame_end)
            note_mismatch($sformatf(
              "word %0d: exp row %0d col %0d val %0d last %b done %b, got %0d %0d %0d %b %b",
              words_out, want.row, want.col, want.value, want.run_end, want.frame_end,
              res_ch.out_row, res_ch.out_col, res_ch.out_value, res_ch.last_of_run,
              res_ch.frame_done));
        end
        if (res_ch.frame_done === 1'b1) frames_done++;
        words_out++;
      end
    end
  end

  initial begin
    int w, h, r, c, n, frame_px, rem, sent;
    logic [CFG_W-1:0] new_w, new_h;
    src_ch.valid = 1'b0;
    src_ch.src_pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SRC_WIDTH;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].act == DO_REG) begin
        settle();
        write_reg(dir_steps[i].sel, dir_steps[i].reg_val);
      end else begin
        given_q.push_back(dir_steps[i]);
        push_pixel(dir_steps[i].pix);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      new_w = pick_size(8);
      new_h = pick_size(6);
      if (!width_safe(new_w, new_h)) new_w = width_reg;
      if ($urandom_range(0, 1)) begin
        write_reg(REG_SRC_WIDTH, new_w);
        write_reg(REG_SRC_HEIGHT, new_h);
      end else begin
        write_reg(REG_SRC_HEIGHT, new_h);
        write_reg(REG_SRC_WIDTH, new_w);
      end
      w = eff_size(new_w, DEF_MAX_WIDTH);
      h = eff_size(new_h, HEIGHT_LIMIT);
      r = row_at;
      c = col_at;
      wrap_pos(w, h, r, c);
      frame_px = w * h;
      rem = (h - r) * w - c;
      // mostly finish the frame and run whole ones; sometimes break off mid-frame
      if (frame_px <= 48 && $urandom_range(0, 3) != 0)
        n = rem + $urandom_range(0, 2) * frame_px;
      else
        n = $urandom_range(1, 24);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      for (int k = 0; k < n; k++) begin
        calm = sent >= 100 && sent < 160;
        push_pixel(pick_pixel());
        sent++;
      end
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d source pixels, %0d result words, %0d frame ends, %0d reg writes.",
             pixels_in, words_out, frames_done, reg_writes);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("bilinear_upscale_2x_core_tb passed");
    else
      $display("bilinear_upscale_2x_core_tb failed");
    $finish;
  end

  initial begin
    #400000;
    $display("bilinear_upscale_2x_core_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bu2x_pkg.sv
src/bu2x_ifs.sv
src/bilinear_upscale_2x_core.sv
src/bu2x_checker.sv
tb/bilinear_upscale_2x_core_tb.sv
